/* design/mh2_pkg.sv */
package mh2_pkg;

  // mixing multiplier and shift amounts of murmurhash2
  localparam logic [31:0] MixM = 32'h5bd1e995;
  localparam int unsigned MixR = 24;
  localparam int unsigned FinA = 13;
  localparam int unsigned FinB = 15;

  // what the back end does with a word
  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_PART,
    KIND_FULL
  } kind_e;

  // one classified word on its way from front to back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] word;   // mixed word when full, masked tail bytes when partial
    logic [31:0] start;  // seed xor key length
    logic        first;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

/* design/mh2_front.sv */
module mh2_front import mh2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] seed_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] key_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [31:0] key_length_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic        valid_q, valid_d;
  logic [31:0] kmul_q, kmul_d;
  logic [31:0] tail_q, tail_d;
  kind_e       kind_q, kind_d;
  logic [31:0] start_q, start_d;
  logic        first_q, first_d;
  logic        last_q, last_d;
  logic        accept;
  logic [31:0] kx;
  logic [31:0] kmix;

  assign push_o  = valid_q && !q_status_i.full;
  assign ready_o = !valid_q || push_o;
  assign accept  = valid_i && ready_o;

  // classify the beat and run the first multiply of the word mix
  always_comb begin
    kmul_d  = 32'(key_word_i * MixM);
    start_d = seed_i ^ key_length_i;
    first_d = first_i;
    last_d  = last_i;
    case (valid_bytes_i)
      3'd0: begin
        kind_d = KIND_EMPTY;
        tail_d = '0;
      end
      3'd1: begin
        kind_d = KIND_PART;
        tail_d = {24'd0, key_word_i[7:0]};
      end
      3'd2: begin
        kind_d = KIND_PART;
        tail_d = {16'd0, key_word_i[15:0]};
      end
      3'd3: begin
        kind_d = KIND_PART;
        tail_d = {8'd0, key_word_i[23:0]};
      end
      default: begin
        kind_d = KIND_FULL;
        tail_d = '0;
      end
    endcase
    valid_d = accept ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        kmul_q  <= kmul_d;
        tail_q  <= tail_d;
        kind_q  <= kind_d;
        start_q <= start_d;
        first_q <= first_d;
        last_q  <= last_d;
      end
    end
  end

  // xorshift and second multiply, straight into the queue
  assign kx   = kmul_q ^ (kmul_q >> MixR);
  assign kmix = 32'(kx * MixM);

  always_comb begin
    entry_o.kind  = kind_q;
    entry_o.word  = (kind_q == KIND_FULL) ? kmix : tail_q;
    entry_o.start = start_q;
    entry_o.first = first_q;
    entry_o.last  = last_q;
  end

endmodule

/* design/mh2_queue.sv */
module mh2_queue import mh2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    entry_i,
  input  logic      pop_i,
  output entry_t    entry_o,
  output q_status_t status_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o            = mem_q[rd_ptr_q];
  assign status_o.not_empty = (count_q != 2'd0);
  assign status_o.full      = (count_q == 2'd2);

endmodule

/* design/mh2_back.sv */
module mh2_back import mh2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      entry_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  output logic        fin_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] hash_o
);

  typedef enum logic {
    S_EXEC,
    S_FIN
  } state_e;

  state_e      state_q;
  logic [31:0] hash_q;
  logic [31:0] fin_q;
  logic [31:0] out_q;
  logic        out_valid_q;
  logic [31:0] h0;
  logic [31:0] opnd;
  logic [31:0] prod;
  logic [31:0] h_new;
  logic [31:0] g;
  logic [31:0] g_out;
  logic        out_free;

  // one multiply by m on the running hash per full or partial word
  always_comb begin
    h0   = entry_i.first ? entry_i.start : hash_q;
    opnd = (entry_i.kind == KIND_PART) ? (h0 ^ entry_i.word) : h0;
    prod = 32'(opnd * MixM);
    case (entry_i.kind)
      KIND_FULL: h_new = prod ^ entry_i.word;
      KIND_PART: h_new = prod;
      default:   h_new = h0;
    endcase
  end

  assign g        = 32'(fin_q * MixM);
  assign g_out    = g ^ (g >> FinB);
  assign out_free = !out_valid_q || ready_i;
  assign pop_o    = (state_q == S_EXEC) && q_status_i.not_empty;
  assign fin_o    = (state_q == S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      hash_q      <= '0;
      fin_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new hash replaces the one taken in the same cycle
      if (fin_o && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_EXEC: begin
          if (pop_o) begin
            hash_q <= h_new;
            if (entry_i.last) begin
              fin_q   <= h_new ^ (h_new >> FinA);
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q   <= g_out;
            state_q <= S_EXEC;
          end
        end
        default: state_q <= S_EXEC;
      endcase
    end
  end

  assign valid_o = out_valid_q;
  assign hash_o  = out_q;

endmodule

/* design/murmur2_hash_stream.sv */
// channel   dir  handshake                      content
// s_axis    in   s_axis_tvalid / s_axis_tready  key word beat, first flag, last flag
// m_axis    out  m_axis_tvalid / m_axis_tready  finished 32-bit hash
// apb       in   psel, penable, pwrite, pready  hash_seed at byte address 0
//
// the back end takes one beat per cycle while the queue is not empty; a last
// beat moves it to the finalizer state for the finalizer multiply until the
// output register is free; a beat passes the front register and the queue
// before the back end takes it, and its hash then passes the output register
// rst_ni clears the running hash, the seed and all valid state asynchronously
// a two-entry queue parts front and back; input stalls only when the queue
// and front stage are full, the back in its finalizer state, kept while a hash waits
module murmur2_hash_stream import mh2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: key_word[31:0], valid_bytes[34:32], key_length[66:35], zero pad
  input  logic [71:0] s_axis_tdata,
  // fields from bit 0: first_word
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fields from bit 0: hash_value[31:0]
  output logic [31:0] m_axis_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] seed_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        fin_busy;
  entry_t      front_entry;
  entry_t      back_entry;
  q_status_t   q_status;

  // register file: one word, address bit 2 selects beyond the list
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_wr) begin
      seed_q <= pwdata;
    end
  end

  // front: classify beat, mask tail bytes, mix full words
  mh2_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .key_word_i    (s_axis_tdata[31:0]),
    .valid_bytes_i (s_axis_tdata[34:32]),
    .first_i       (s_axis_tuser),
    .last_i        (s_axis_tlast),
    .key_length_i  (s_axis_tdata[66:35]),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  mh2_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (back_entry),
    .status_o (q_status)
  );

  // back: running hash update, finalizer, output register
  mh2_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (back_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .fin_o      (fin_busy),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .hash_o     (m_axis_tdata)
  );

  // a new hash only comes out of the finalizer step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(fin_busy))
    else $error("hash presented without finalizer step");

  // the back end never reads an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_status.not_empty)
    else $error("queue popped while empty");

  // the front never writes a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue pushed while full");

  // no beat is taken from the queue while the finalizer holds the back end
  a_no_pop_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_busy |-> !pop)
    else $error("queue popped during finalizer");

endmodule
